FILE: hw/rtl/cssu_pkg.sv
// shared constants and types for the circular station step selector
package cssu_pkg;

    // station space and cell partitioning
    localparam int MAX_STATIONS = 64;
    localparam int CELL_W       = 8;
    localparam int NUM_CELLS    = MAX_STATIONS / CELL_W;

    // field widths
    localparam int REQ_W     = 2;
    localparam int CUR_W     = 8;
    localparam int STA_W     = 6;
    localparam int CNT_W     = 7;
    localparam int MASK_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    // request codes
    localparam logic [REQ_W-1:0] REQ_NEXT_WRAP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PREV_WRAP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NEXT_STOP = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISABLED_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_ONE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_TWO    = 2'd3;

    // partial search result carried from cell to cell
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [CUR_W-1:0] cur;
        logic             cur_ok;
        logic             set_hit;
        logic [STA_W-1:0] low_idx;
        logic [STA_W-1:0] high_idx;
        logic             above_hit;
        logic [STA_W-1:0] above_idx;
        logic             below_hit;
        logic [STA_W-1:0] below_idx;
    } tok_t;

endpackage

FILE: hw/rtl/cssu_if.sv
// request and result channel interfaces

interface cssu_in_if;
    import cssu_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [CUR_W-1:0] current_station;

    modport source (output valid, output req_type, output current_station, input ready);
    modport sink   (input valid, input req_type, input current_station, output ready);
endinterface

interface cssu_out_if;
    import cssu_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [STA_W-1:0] station;

    modport source (output valid, output found, output station, input ready);
    modport sink   (input valid, input found, input station, output ready);
endinterface

FILE: hw/rtl/circular_station_step_selector_unit.sv
// top level: configuration registers, chain of search cells and result stage
// path: each request word passes through every cell register and then the result register
// throughput: one request per cycle; each cell stage stalls only when full and blocked
// reset: clears all valid bits and all configuration registers (no station runnable)
module circular_station_step_selector_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cssu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cssu_pkg::CFG_W-1:0]       cfg_data,
    cssu_in_if.sink                          req,
    cssu_out_if.source                       res
);
    import cssu_pkg::*;

    logic [CNT_W-1:0]        station_count_reg;
    logic [MAX_STATIONS-1:0] disabled_reg;
    logic [MAX_STATIONS-1:0] master_one_reg;
    logic [MAX_STATIONS-1:0] master_two_reg;
    logic [MAX_STATIONS-1:0] runnable;

    logic                    chain_valid [NUM_CELLS+1];
    logic                    chain_ready [NUM_CELLS+1];
    tok_t                    chain_tok   [NUM_CELLS+1];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_count_reg <= '0;
            disabled_reg      <= '0;
            master_one_reg    <= '0;
            master_two_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STATION_COUNT: station_count_reg <= cfg_data[CNT_W-1:0];
                CFG_DISABLED_MASK: disabled_reg      <= cfg_data[MAX_STATIONS-1:0];
                CFG_MASTER_ONE:    master_one_reg    <= cfg_data[MAX_STATIONS-1:0];
                CFG_MASTER_TWO:    master_two_reg    <= cfg_data[MAX_STATIONS-1:0];
                default:           station_count_reg <= station_count_reg;
            endcase
        end
    end

    // runnable set: present and not disabled and no master bit
    always_comb
    begin
        for (int i = 0; i < MAX_STATIONS; i++)
        begin
            runnable[i] = (CNT_W'(i) < station_count_reg) & ~disabled_reg[i]
                        & ~master_one_reg[i] & ~master_two_reg[i];
        end
    end

    // request word enters the chain with an empty result
    always_comb
    begin
        chain_tok[0]          = '0;
        chain_tok[0].req_type = req.req_type;
        chain_tok[0].cur      = req.current_station;
    end
    assign chain_valid[0] = req.valid;
    assign req.ready      = chain_ready[0];

    // row of search cells, lowest stations first
    for (genvar c = 0; c < NUM_CELLS; c++)
    begin : g_cell
        cssu_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .base     (STA_W'(c * CELL_W)),
            .run      (runnable[c*CELL_W +: CELL_W]),
            .up_valid (chain_valid[c]),
            .up_ready (chain_ready[c]),
            .up_tok   (chain_tok[c]),
            .dn_valid (chain_valid[c+1]),
            .dn_ready (chain_ready[c+1]),
            .dn_tok   (chain_tok[c+1])
        );
    end

    // result stage
    cssu_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[NUM_CELLS]),
        .up_ready (chain_ready[NUM_CELLS]),
        .up_tok   (chain_tok[NUM_CELLS]),
        .res      (res)
    );

endmodule

FILE: hw/rtl/cssu_cell.sv
// one search cell: scans its slice of stations and updates the running result
module cssu_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [cssu_pkg::STA_W-1:0]        base,
    input  logic [cssu_pkg::CELL_W-1:0]       run,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  cssu_pkg::tok_t                    up_tok,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output cssu_pkg::tok_t                    dn_tok
);
    import cssu_pkg::*;

    logic valid_reg;
    tok_t tok_reg;
    tok_t tok_next;

    // stage moves when empty or when the neighbor takes the word
    assign up_ready = ~valid_reg | dn_ready;
    assign dn_valid = valid_reg;
    assign dn_tok   = tok_reg;

    // scan the slice in ascending order
    always_comb
    begin
        logic [STA_W-1:0] sta;
        logic [STA_W-1:0] cur_lo;
        logic             cur_in_range;
        cur_lo       = up_tok.cur[STA_W-1:0];
        cur_in_range = (up_tok.cur[CUR_W-1:STA_W] == '0);
        tok_next     = up_tok;
        for (int j = 0; j < CELL_W; j++)
        begin
            sta = base + STA_W'(j);
            if (run[j])
            begin
                if (!tok_next.set_hit)
                begin
                    tok_next.set_hit = 1'b1;
                    tok_next.low_idx = sta;
                end
                tok_next.high_idx = sta;
                if (sta > cur_lo && !tok_next.above_hit)
                begin
                    tok_next.above_hit = 1'b1;
                    tok_next.above_idx = sta;
                end
                if (sta < cur_lo)
                begin
                    tok_next.below_hit = 1'b1;
                    tok_next.below_idx = sta;
                end
                if (cur_in_range && sta == cur_lo)
                begin
                    tok_next.cur_ok = 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            tok_reg <= tok_next;
        end
    end

endmodule

FILE: hw/rtl/cssu_out.sv
// result stage: picks the answer for the request code and holds the output word
module cssu_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  cssu_pkg::tok_t up_tok,
    cssu_out_if.source     res
);
    import cssu_pkg::*;

    logic             valid_reg;
    logic             found_reg;
    logic [STA_W-1:0] station_reg;
    logic             found_next;
    logic [STA_W-1:0] pick;

    assign up_ready    = ~valid_reg | res.ready;
    assign res.valid   = valid_reg;
    assign res.found   = found_reg;
    assign res.station = station_reg;

    // answer selection
    always_comb
    begin
        found_next = 1'b0;
        pick       = '0;
        case (up_tok.req_type)
            REQ_NEXT_WRAP:
            begin
                found_next = up_tok.set_hit;
                pick = (up_tok.cur_ok && up_tok.above_hit) ? up_tok.above_idx
                                                           : up_tok.low_idx;
            end
            REQ_PREV_WRAP:
            begin
                found_next = up_tok.set_hit;
                pick = (up_tok.cur_ok && up_tok.below_hit) ? up_tok.below_idx
                                                           : up_tok.high_idx;
            end
            REQ_NEXT_STOP:
            begin
                found_next = up_tok.cur_ok && up_tok.above_hit;
                pick       = up_tok.above_idx;
            end
            default:
            begin
                found_next = 1'b0;
                pick       = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            found_reg   <= found_next;
            station_reg <= found_next ? pick : '0;
        end
    end

endmodule
